### hdl/display_scan_button_repeat_tick_core_assert.svh
// Assertion macros for the display scan and button repeat tick core.
// Depends on nothing; included by the modules that assert.
`ifndef DISPLAY_SCAN_BUTTON_REPEAT_TICK_CORE_ASSERT_SVH
`define DISPLAY_SCAN_BUTTON_REPEAT_TICK_CORE_ASSERT_SVH

// check a property at every rising clock edge outside reset
`define DSBRT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property at every rising clock edge, reset included
`define DSBRT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/dsbrt_pkg.sv
// Shared types and constants for the display scan and button repeat tick core.
// Depends on nothing.
package dsbrt_pkg;

   localparam int AGE_BITS_DEF = 10;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_DIGIT = 2'd1,
      CMD_RELAY = 2'd2,
      CMD_LINK  = 2'd3
   } cmd_type;

   localparam logic [2:0] REG_PRESS_DELAY   = 3'd0;
   localparam logic [2:0] REG_REPEAT_START  = 3'd1;
   localparam logic [2:0] REG_REPEAT_RELOAD = 3'd2;
   localparam logic [2:0] REG_RELAY_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_TOP_CHANNEL   = 3'd4;

   localparam logic [9:0] PRESS_DELAY_RST   = 10'd5;
   localparam logic [9:0] REPEAT_START_RST  = 10'd500;
   localparam logic [9:0] REPEAT_RELOAD_RST = 10'd250;
   localparam logic [7:0] RELAY_TIMEOUT_RST = 8'd200;
   localparam logic [3:0] TOP_CHANNEL_RST   = 4'd15;

   localparam logic [7:0] SELECT_BASE = 8'hF7;
   localparam logic [7:0] LINK_MARK   = 8'h80;
   localparam logic [7:0] RELAY_AGE_MAX = 8'hFF;

   typedef struct packed {
      logic [9:0] press_delay;
      logic [9:0] repeat_start;
      logic [9:0] repeat_reload;
      logic [3:0] top_channel;
   } key_cfg_type;

endpackage

### hdl/display_scan_button_repeat_tick_core.sv
// Tick controller: four-digit display scan, relay byte timeout, button channel stepping.
// A tick beat's result is registered and shows in the cycle after the beat is accepted.
// Throughput: one beat per cycle while no result waits or rsp_tready is high; the single
// result register and valid flag set the rate, refilling in the cycle it is drained.
// Reset is synchronous and clears state (not result data) and configuration to defaults.
// Depends on dsbrt_pkg, dsbrt_keys and the assertion macro header.
`include "display_scan_button_repeat_tick_core_assert.svh"

module display_scan_button_repeat_tick_core
   import dsbrt_pkg::*;
#(
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] button_levels, [3:2] digit_index, [11:4] item_value, [15:12] zero
   input  logic [15:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] relay_byte, [15:8] digit_select, [23:16] segment_pattern,
   // [27:24] channel, [31:28] zero
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [9:0]  csr_data
);

   logic [9:0] press_delay_ff;
   logic [9:0] repeat_start_ff;
   logic [9:0] repeat_reload_ff;
   logic [7:0] relay_timeout_ff;
   logic [3:0] top_channel_ff;

   logic [7:0]  digit_ff [4];
   logic [1:0]  scan_ff;
   logic [7:0]  relay_ff;
   logic [7:0]  relay_age_ff;
   logic        link_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic        accept;
   logic        tick;
   cmd_type     cmd;
   logic [1:0]  levels;
   logic [1:0]  idx;
   logic [7:0]  value;
   logic [7:0]  digit1_mark;
   logic [7:0]  segment;
   logic [7:0]  select;
   logic [7:0]  relay_in;
   logic [7:0]  relay_age_in;
   logic [3:0]  channel_next;
   key_cfg_type key_cfg;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign accept = req_tvalid && req_tready;
   assign cmd    = cmd_type'(req_tuser);
   assign tick   = accept && (cmd == CMD_TICK);
   assign levels = req_tdata[1:0];
   assign idx    = req_tdata[3:2];
   assign value  = req_tdata[11:4];

   assign digit1_mark = link_ff ? (digit_ff[1] | LINK_MARK) : digit_ff[1];
   assign segment     = (~scan_ff == 2'd1) ? digit1_mark : digit_ff[~scan_ff];
   assign select      = SELECT_BASE >> scan_ff;

   always_comb begin
      logic [7:0] age;
      age          = (relay_age_ff != RELAY_AGE_MAX) ? relay_age_ff + 1'b1 : relay_age_ff;
      relay_in     = relay_ff;
      relay_age_in = relay_age_ff;
      if (relay_ff != 8'd0) begin
         if (age > relay_timeout_ff) begin
            relay_in     = 8'd0;
            relay_age_in = 8'd0;
         end else begin
            relay_age_in = age;
         end
      end
   end

   assign key_cfg.press_delay   = press_delay_ff;
   assign key_cfg.repeat_start  = repeat_start_ff;
   assign key_cfg.repeat_reload = repeat_reload_ff;
   assign key_cfg.top_channel   = top_channel_ff;

   dsbrt_keys #(
      .AGE_BITS(AGE_BITS)
   ) u_keys (
      .clock        (clock),
      .reset        (reset),
      .step         (tick),
      .levels       (levels),
      .cfg          (key_cfg),
      .channel_next (channel_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         press_delay_ff   <= PRESS_DELAY_RST;
         repeat_start_ff  <= REPEAT_START_RST;
         repeat_reload_ff <= REPEAT_RELOAD_RST;
         relay_timeout_ff <= RELAY_TIMEOUT_RST;
         top_channel_ff   <= TOP_CHANNEL_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PRESS_DELAY:   press_delay_ff   <= csr_data;
            REG_REPEAT_START:  repeat_start_ff  <= csr_data;
            REG_REPEAT_RELOAD: repeat_reload_ff <= csr_data;
            REG_RELAY_TIMEOUT: relay_timeout_ff <= csr_data[7:0];
            REG_TOP_CHANNEL:   top_channel_ff   <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff[0]  <= '0;
         digit_ff[1]  <= '0;
         digit_ff[2]  <= '0;
         digit_ff[3]  <= '0;
         scan_ff      <= '0;
         relay_ff     <= '0;
         relay_age_ff <= '0;
         link_ff      <= 1'b0;
      end else if (accept) begin
         case (cmd)
            CMD_TICK: begin
               digit_ff[1]  <= digit1_mark;
               scan_ff      <= scan_ff + 1'b1;
               relay_ff     <= relay_in;
               relay_age_ff <= relay_age_in;
            end
            CMD_DIGIT: digit_ff[idx] <= value;
            CMD_RELAY: begin
               relay_ff     <= value;
               relay_age_ff <= '0;
            end
            CMD_LINK: link_ff <= value[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_data_ff <= {4'd0, channel_next, segment, select, relay_ff};
      end
   end

   `DSBRT_ASSERT(a_tick_gives_beat, clock, reset, tick |=> rsp_tvalid, "tick beat lost")
   `DSBRT_ASSERT(a_scan_advances, clock, reset, tick |=> (scan_ff == $past(scan_ff) + 2'd1), "scan index did not advance")
   `DSBRT_ASSERT(a_no_spurious_beat, clock, reset, (accept && cmd != CMD_TICK && rsp_tready) |=> !rsp_tvalid, "result from non-tick beat")
   `DSBRT_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

### hdl/dsbrt_keys.sv
// Button age counters and channel stepping for the down and up buttons.
// Depends on dsbrt_pkg.
module dsbrt_keys
   import dsbrt_pkg::*;
#(
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [1:0]  levels,
   input  key_cfg_type cfg,
   output logic [3:0]  channel_next
);

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   logic [AGE_BITS-1:0] held_ff [2];
   logic [AGE_BITS-1:0] held_in [2];
   logic [3:0]          channel_ff;
   logic [3:0]          channel_in;

   always_comb begin
      logic [AGE_BITS-1:0] a0;
      logic [AGE_BITS-1:0] a1;
      logic [AGE_BITS-1:0] pd;
      logic [AGE_BITS-1:0] rs;
      logic [AGE_BITS-1:0] rl;
      logic [3:0]          c;
      pd = AGE_BITS'(cfg.press_delay);
      rs = AGE_BITS'(cfg.repeat_start);
      rl = AGE_BITS'(cfg.repeat_reload);
      a0 = levels[0] ? '0 : ((held_ff[0] != AGE_MAX) ? held_ff[0] + 1'b1 : held_ff[0]);
      a1 = levels[1] ? '0 : ((held_ff[1] != AGE_MAX) ? held_ff[1] + 1'b1 : held_ff[1]);
      c = channel_ff;
      if (a0 == pd && c != 4'd0) begin
         c = c - 1'b1;
      end
      if (a0 == rs && c != 4'd0) begin
         c  = c - 1'b1;
         a0 = rl;
      end
      if (a1 == pd && c < cfg.top_channel) begin
         c = c + 1'b1;
      end
      if (a1 == rs && c < cfg.top_channel) begin
         c  = c + 1'b1;
         a1 = rl;
      end
      held_in[0] = a0;
      held_in[1] = a1;
      channel_in = c;
   end

   assign channel_next = channel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff[0] <= '0;
         held_ff[1] <= '0;
         channel_ff <= '0;
      end else if (step) begin
         held_ff[0] <= held_in[0];
         held_ff[1] <= held_in[1];
         channel_ff <= channel_in;
      end
   end

endmodule

### tb/display_scan_button_repeat_tick_core_test.sv
// Self-checking testbench for display_scan_button_repeat_tick_core: predicts every shift word
// from its own copy of the scan, relay and button state. Depends on dsbrt_pkg and the RTL.
module display_scan_button_repeat_tick_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dsbrt_pkg::*;

   localparam int LIMIT = 500000;
   localparam int MAX_REPORTS = 100;
   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST = 3'd7;
   localparam logic [AGE_BITS_DEF-1:0] HELD_MAX = '1;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] levels;
      logic [1:0] digit_idx;
      logic [7:0] value;
   } panel_item_t;

   typedef struct packed {
      logic [7:0] relay;
      logic [7:0] select;
      logic [7:0] segment;
      logic [3:0] channel;
   } shift_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [9:0]  csr_data = '0;

   display_scan_button_repeat_tick_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted panel state and register copies
   logic [7:0]              pred_digits [4];
   logic [1:0]              pred_scan;
   logic [7:0]              pred_relay;
   logic [7:0]              pred_relay_age;
   logic [AGE_BITS_DEF-1:0] pred_held [2];
   logic [3:0]              pred_chan;
   logic                    pred_link;
   logic [9:0]              cfg_press;
   logic [9:0]              cfg_repeat;
   logic [9:0]              cfg_reload;
   logic [7:0]              cfg_timeout;
   logic [3:0]              cfg_top;

   panel_item_t beats_to_send [$];
   shift_word_t words_due [$];

   int  errors = 0;
   int  beats_in = 0;
   int  ticks_in = 0;
   int  words_checked = 0;
   int  reg_writes = 0;
   int  cycle = 0;
   bit  req_fired = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   int  rx_mode = 0;
   int  rx_count = 0;
   int  rx_phase = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MAX_REPORTS)
         $display("[%0d] mismatch %s: got 0x%0h expected 0x%0h", cycle, what, got, want);
      errors++;
   endtask

   task automatic advance_panel(input panel_item_t it);
      shift_word_t w;
      case (it.cmd)
         CMD_DIGIT: pred_digits[it.digit_idx] = it.value;
         CMD_RELAY: begin
            pred_relay = it.value;
            pred_relay_age = '0;
         end
         CMD_LINK: pred_link = it.value[0];
         default: begin
            if (pred_link)
               pred_digits[1] = pred_digits[1] | LINK_MARK;
            w.relay = pred_relay;
            w.select = SELECT_BASE >> pred_scan;
            w.segment = pred_digits[2'd3 - pred_scan];
            pred_scan = pred_scan + 2'd1;
            if (pred_relay != '0) begin
               if (pred_relay_age != RELAY_AGE_MAX)
                  pred_relay_age = pred_relay_age + 8'd1;
               if (pred_relay_age > cfg_timeout) begin
                  pred_relay = '0;
                  pred_relay_age = '0;
               end
            end
            for (int k = 0; k < 2; k++) begin
               if (it.levels[k])
                  pred_held[k] = '0;
               else if (pred_held[k] != HELD_MAX)
                  pred_held[k] = pred_held[k] + 1'b1;
            end
            if (pred_held[0] == cfg_press && pred_chan > 4'd0)
               pred_chan = pred_chan - 4'd1;
            if (pred_held[0] == cfg_repeat && pred_chan > 4'd0) begin
               pred_chan = pred_chan - 4'd1;
               pred_held[0] = cfg_reload;
            end
            if (pred_held[1] == cfg_press && pred_chan < cfg_top)
               pred_chan = pred_chan + 4'd1;
            if (pred_held[1] == cfg_repeat && pred_chan < cfg_top) begin
               pred_chan = pred_chan + 4'd1;
               pred_held[1] = cfg_reload;
            end
            w.channel = pred_chan;
            words_due.push_back(w);
         end
      endcase
   endtask

   // monitor, predictor update and run limit
   always @(posedge clock) begin : monitor
      shift_word_t got;
      shift_word_t want;
      panel_item_t seen;
      cycle++;
      if (cycle >= LIMIT) begin
         $display("timeout after %0d cycles, %0d shift words outstanding", cycle,
                  words_due.size());
         $display("display_scan_button_repeat_tick_core_test NOT OK");
         $finish;
      end else if (reset) begin
         req_fired = 1'b0;
         for (int i = 0; i < 4; i++)
            pred_digits[i] = '0;
         pred_scan = '0;
         pred_relay = '0;
         pred_relay_age = '0;
         pred_held[0] = '0;
         pred_held[1] = '0;
         pred_chan = '0;
         pred_link = 1'b0;
         cfg_press = PRESS_DELAY_RST;
         cfg_repeat = REPEAT_START_RST;
         cfg_reload = REPEAT_RELOAD_RST;
         cfg_timeout = RELAY_TIMEOUT_RST;
         cfg_top = TOP_CHANNEL_RST;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.relay = rsp_tdata[7:0];
            got.select = rsp_tdata[15:8];
            got.segment = rsp_tdata[23:16];
            got.channel = rsp_tdata[27:24];
            if (words_due.size() == 0) begin
               report_mismatch("unexpected shift word", rsp_tdata, '0);
            end else begin
               want = words_due.pop_front();
               if (got.relay !== want.relay)
                  report_mismatch("relay_byte", got.relay, want.relay);
               if (got.select !== want.select)
                  report_mismatch("digit_select", got.select, want.select);
               if (got.segment !== want.segment)
                  report_mismatch("segment_pattern", got.segment, want.segment);
               if (got.channel !== want.channel)
                  report_mismatch("channel", got.channel, want.channel);
               words_checked++;
            end
         end
         req_fired = req_tvalid && req_tready;
         if (req_fired) begin
            seen.cmd = cmd_type'(req_tuser);
            seen.levels = req_tdata[1:0];
            seen.digit_idx = req_tdata[3:2];
            seen.value = req_tdata[11:4];
            if (seen.cmd == CMD_TICK)
               ticks_in++;
            advance_panel(seen);
            void'(beats_to_send.pop_front());
            beats_in++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PRESS_DELAY:   cfg_press = csr_data;
               REG_REPEAT_START:  cfg_repeat = csr_data;
               REG_REPEAT_RELOAD: cfg_reload = csr_data;
               REG_RELAY_TIMEOUT: cfg_timeout = csr_data[7:0];
               REG_TOP_CHANNEL:   cfg_top = csr_data[3:0];
               default: ;
            endcase
            reg_writes++;
         end
      end
   end

   // request driver: bursts of beats separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // hold the beat until it is taken
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left--;
      end else if (beats_to_send.size() > 0) begin
         req_tuser <= beats_to_send[0].cmd;
         req_tdata <= {4'b0, beats_to_send[0].value, beats_to_send[0].digit_idx,
                       beats_to_send[0].levels};
         req_tvalid <= 1'b1;
         if (burst_left > 0)
            burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_count == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_count = $urandom_range(20, 120);
         end else begin
            rx_count--;
         end
         rx_phase = (rx_phase + 1) % 5;
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= (rx_phase != 0);
            default: rsp_tready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [9:0] data);
      int n;
      n = reg_writes;
      @(negedge clock);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(negedge clock); while (reg_writes == n);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [9:0] press, logic [9:0] rep, logic [9:0] reload,
                            logic [7:0] timeout, logic [3:0] top);
      write_reg(REG_PRESS_DELAY, press);
      write_reg(REG_REPEAT_START, rep);
      write_reg(REG_REPEAT_RELOAD, reload);
      write_reg(REG_RELAY_TIMEOUT, {2'($urandom_range(0, 3)), timeout});
      write_reg(REG_TOP_CHANNEL, {6'($urandom_range(0, 63)), top});
      write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 10'($urandom));
   endtask

   // wait until every beat is sent and every shift word is back, then drain
   task automatic settle();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || words_due.size() != 0 || req_tvalid);
      repeat (4) @(negedge clock);
   endtask

   task automatic add_beat(cmd_type c, logic [1:0] lv, logic [1:0] ix, logic [7:0] v);
      panel_item_t it;
      it.cmd = c;
      it.levels = lv;
      it.digit_idx = ix;
      it.value = v;
      beats_to_send.push_back(it);
   endtask

   task automatic add_hold(logic [1:0] lv, int len, bit mixed);
      for (int i = 0; i < len; i++) begin
         if (mixed && $urandom_range(0, 7) == 0)
            add_beat(cmd_type'($urandom_range(CMD_DIGIT, CMD_LINK)), 2'($urandom),
                     2'($urandom), 8'($urandom));
         add_beat(CMD_TICK, lv, 2'($urandom), 8'($urandom));
      end
   endtask

   // mostly held-button runs with random content, the rest raw noise
   task automatic fill_phase(int n);
      int count;
      int cap;
      int len;
      count = 0;
      cap = (cfg_repeat > 40) ? 46 : int'(cfg_repeat) + 6;
      while (count < n) begin
         if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(1, cap);
            add_hold(2'($urandom), len, 1'b1);
            count += len;
         end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               add_beat(cmd_type'($urandom_range(CMD_TICK, CMD_LINK)), 2'($urandom),
                        2'($urandom), 8'($urandom));
            count += len;
         end
      end
   endtask

   initial begin : stimulus
      int n;
      int len;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // directed: digit loads, link mark, relay extremes, button level corners
      add_beat(CMD_DIGIT, 2'b00, 2'd0, 8'h3F);
      add_beat(CMD_DIGIT, 2'b11, 2'd1, 8'h06);
      add_beat(CMD_DIGIT, 2'b01, 2'd2, 8'hFF);
      add_beat(CMD_DIGIT, 2'b10, 2'd3, 8'h00);
      add_beat(CMD_LINK, 2'b11, 2'd0, 8'hFF);
      add_beat(CMD_RELAY, 2'b11, 2'd0, 8'hFF);
      add_beat(CMD_TICK, 2'b11, 2'd0, 8'h00);
      add_beat(CMD_TICK, 2'b00, 2'd3, 8'hFF);
      add_beat(CMD_TICK, 2'b01, 2'd1, 8'h00);
      add_beat(CMD_TICK, 2'b10, 2'd2, 8'hFF);
      add_beat(CMD_LINK, 2'b00, 2'd3, 8'hFE);
      add_beat(CMD_DIGIT, 2'b00, 2'd1, 8'h5B);
      add_hold(2'b11, 4, 1'b0);
      add_beat(CMD_RELAY, 2'b00, 2'd3, 8'h00);
      add_beat(CMD_TICK, 2'b11, 2'd0, 8'h00);
      add_beat(CMD_RELAY, 2'b00, 2'd2, 8'h01);
      add_hold(2'b00, 2, 1'b0);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: configure(10'd1, 10'd1, 10'd0, 8'd0, 4'd0);
            1: configure(10'd1022, 10'd1022, 10'd1022, 8'd254, 4'd15);
            2: configure(10'd0, 10'd0, 10'd5, 8'd255, 4'd15);
            3: configure(10'd3, 10'd3, 10'd1, 8'd4, 4'd9);
            default: configure(10'($urandom_range(1, 8)), 10'($urandom_range(1, 20)),
                               10'($urandom_range(0, 20)), 8'($urandom_range(0, 10)),
                               4'($urandom_range(0, 15)));
         endcase
         fill_phase(60);
         settle();
      end

      // drop the top channel to 2 and let the relay age towards its timeout
      configure(10'd3, 10'd7, 10'd2, 8'd254, 4'd2);
      add_beat(CMD_RELAY, 2'b11, 2'd0, 8'h5A);
      n = 0;
      while (n < 250) begin
         len = $urandom_range(1, 12);
         add_hold(2'($urandom), len, 1'b0);
         n += len;
      end
      settle();
      repeat (10) @(negedge clock);

      $display("covered %0d request beats (%0d ticks) and %0d register writes", beats_in,
               ticks_in, reg_writes);
      $display("checked %0d shift words, %0d mismatches", words_checked, errors);
      if (errors == 0)
         $display("display_scan_button_repeat_tick_core_test OK");
      else
         $display("display_scan_button_repeat_tick_core_test NOT OK");
      $finish;
   end

endmodule
